@@ sv/amr_toc_pkg.sv @@
// shared types, sizes and the frame length table of the amr toc deframer
// no dependencies; used by amr_toc_out_if, the core and the testbench
package amr_toc_pkg;

  localparam int MaxToc    = 16;
  localparam int TocIdxW   = (MaxToc > 1) ? $clog2(MaxToc) : 1;
  localparam int TocCntW   = $clog2(MaxToc + 1);
  localparam int FrameLenW = 5;
  localparam int FrameCntW = 5;
  localparam int StatusW   = 3;

  localparam logic [TocCntW-1:0]   MaxTocCnt   = TocCntW'(MaxToc);
  localparam logic [FrameCntW-1:0] FrameCntMax = '1;
  // type indexes from this value up carry no speech frame we can size
  localparam logic [3:0]           NumTypes    = 4'd9;

  typedef enum logic [StatusW-1:0] {
    StOk      = 3'd0,
    StShort   = 3'd1,
    StTocOpen = 3'd2,
    StBadType = 3'd3,
    StTrunc   = 3'd4,
    StTocOvf  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic                 frame_start;
    logic                 frame_end;
    logic                 packet_done;
    status_t              status;
    logic [FrameCntW-1:0] frames_done;
    logic                 run_end;
  } result_t;

  // frame length in bytes per type index
  function automatic logic [FrameLenW-1:0] frame_len(input logic [3:0] idx);
    logic [FrameLenW-1:0] len;
    unique case (idx)
      4'd0:    len = 5'd12;
      4'd1:    len = 5'd13;
      4'd2:    len = 5'd15;
      4'd3:    len = 5'd17;
      4'd4:    len = 5'd19;
      4'd5:    len = 5'd20;
      4'd6:    len = 5'd26;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd5;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ sv/amr_toc_if.sv @@
// valid/ready channels of the amr toc deframer: payload words in, result words out
// depends on amr_toc_pkg for field widths
interface amr_toc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source(output valid, output in_byte, output last_byte, input ready);
  modport sink(input valid, input in_byte, input last_byte, output ready);
endinterface

interface amr_toc_out_if;
  logic                                valid;
  logic                                ready;
  logic [7:0]                          out_byte;
  logic                                byte_valid;
  logic                                frame_start;
  logic                                frame_end;
  logic                                packet_done;
  logic [amr_toc_pkg::StatusW-1:0]     status;
  logic [amr_toc_pkg::FrameCntW-1:0]   frames_done;
  logic                                run_end;

  modport source(output valid, output out_byte, output byte_valid, output frame_start,
                 output frame_end, output packet_done, output status, output frames_done,
                 output run_end, input ready);
  modport sink(input valid, input out_byte, input byte_valid, input frame_start,
               input frame_end, input packet_done, input status, input frames_done,
               input run_end, output ready);
endinterface

@@ sv/amr_payload_toc_deframer_core.sv @@
// output: result words are registered in the output queue and offered on the result port from there
// throughput: one payload word per cycle; the word that opens a frame makes two result
//   words (toc byte and first data byte), so the output port, one word a cycle, sets the pace
//   and the input holds off while fewer than two of the four queue slots are free
// reset: control state, counters and the output queue clear at once; the toc memory
//   keeps its contents and needs no clearing pass
module amr_payload_toc_deframer_core (
  input logic            clk,
  input logic            rst,
  amr_toc_in_if.sink     payload,
  amr_toc_out_if.source  result
);
  import amr_toc_pkg::*;

  typedef enum logic [2:0] {
    PhHeader,
    PhToc,
    PhFirst,
    PhBody,
    PhTrail,
    PhDrain
  } phase_t;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // packet control state
  phase_t               phase, phase_next;
  logic [TocCntW-1:0]   toc_count, toc_count_next;
  logic [TocCntW-1:0]   toc_cursor, toc_cursor_next;
  logic [FrameLenW-1:0] bytes_left, bytes_left_next;
  status_t              error_code, error_code_next;
  logic [FrameCntW-1:0] frame_total, frame_total_next;

  // toc byte of the frame in progress, and entry 0 kept aside for the list end
  logic [7:0] cur_toc, cur_toc_next;
  logic [7:0] toc_head, toc_head_next;

  // toc memory: one write port (list capture), one registered read port
  logic [7:0]         toc_mem [MaxToc];
  logic [7:0]         rd_q;
  logic [TocIdxW-1:0] rd_addr;
  logic [TocIdxW-1:0] wr_addr;
  logic               mem_we;
  logic [TocCntW-1:0] cursor_inc;

  // output queue
  result_t           queue [QDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  fill;
  logic              pop;

  logic              accept;
  result_t           res [2];
  logic [1:0]        n_res;

  // frame start helper signals
  logic              begin_en;
  logic [7:0]        begin_entry;
  logic [3:0]        begin_idx;
  logic [TocCntW-1:0] cnt_inc;
  logic [FrameLenW-1:0] bl_dec;
  logic [FrameCntW-1:0] ft_inc;
  status_t           close_status;

  assign accept        = payload.valid & payload.ready;
  assign payload.ready = (fill <= QCntW'(QDepth - 2));

  // the read port always looks one entry past the cursor; a frame lasts at least
  // five words, so the next toc entry has settled in rd_q well before it is needed
  assign cursor_inc = toc_cursor + 1'b1;
  assign rd_addr    = cursor_inc[TocIdxW-1:0];
  assign wr_addr    = toc_count[TocIdxW-1:0];
  assign mem_we     = accept && (phase == PhToc) && (toc_count < MaxTocCnt);

  always_ff @(posedge clk) begin
    rd_q <= toc_mem[rd_addr];
    if (mem_we) begin
      toc_mem[wr_addr] <= payload.in_byte;
    end
  end

  always_comb begin
    phase_next       = phase;
    toc_count_next   = toc_count;
    toc_cursor_next  = toc_cursor;
    bytes_left_next  = bytes_left;
    error_code_next  = error_code;
    frame_total_next = frame_total;
    cur_toc_next     = cur_toc;
    toc_head_next    = toc_head;
    n_res            = 2'd0;
    res[0]           = '0;
    res[1]           = '0;
    begin_en         = 1'b0;
    begin_entry      = rd_q;
    begin_idx        = 4'd0;
    cnt_inc          = toc_count + 1'b1;
    bl_dec           = (bytes_left != '0) ? bytes_left - 1'b1 : bytes_left;
    ft_inc           = (frame_total != FrameCntMax) ? frame_total + 1'b1 : frame_total;
    close_status     = StOk;

    if (accept) begin
      unique case (phase)
        PhHeader: begin
          // cmr byte is dropped
          if (!payload.last_byte) begin
            phase_next = PhToc;
          end
        end
        PhToc: begin
          if (toc_count < MaxTocCnt) begin
            toc_count_next = cnt_inc;
          end
          if (toc_count == '0) begin
            toc_head_next = payload.in_byte;
          end
          if (payload.in_byte[7]) begin
            // follow bit set on the entry that fills the store
            if (cnt_inc >= MaxTocCnt) begin
              error_code_next = StTocOvf;
              phase_next      = PhDrain;
            end
          end else begin
            toc_cursor_next = '0;
            begin_en        = 1'b1;
            begin_entry     = (toc_count == '0) ? payload.in_byte : toc_head;
          end
        end
        PhFirst, PhBody: begin
          // a frame cut short by the packet end emits nothing more
          if (!(payload.last_byte && (bytes_left > FrameLenW'(1)))) begin
            if (phase == PhFirst) begin
              res[n_res[0]].out_byte    = cur_toc;
              res[n_res[0]].byte_valid  = 1'b1;
              res[n_res[0]].frame_start = 1'b1;
              res[n_res[0]].frames_done = frame_total;
              n_res                     = n_res + 1'b1;
              phase_next                = PhBody;
            end
            bytes_left_next = bl_dec;
            res[n_res[0]].out_byte   = payload.in_byte;
            res[n_res[0]].byte_valid = 1'b1;
            if (bl_dec == '0) begin
              frame_total_next          = ft_inc;
              res[n_res[0]].frame_end   = 1'b1;
              res[n_res[0]].frames_done = ft_inc;
              toc_cursor_next           = cursor_inc;
              if (cursor_inc >= toc_count) begin
                phase_next = PhTrail;
              end else begin
                begin_en    = 1'b1;
                begin_entry = rd_q;
              end
            end else begin
              res[n_res[0]].frames_done = frame_total;
            end
            n_res = n_res + 1'b1;
          end
        end
        default: begin
          // trailing bytes and drain after an error are ignored
        end
      endcase

      // size the next frame from its type index, or drain on a type index that cannot be sized
      if (begin_en) begin
        begin_idx = begin_entry[6:3];
        if (begin_idx >= NumTypes) begin
          error_code_next = StBadType;
          phase_next      = PhDrain;
        end else begin
          bytes_left_next = frame_len(begin_idx);
          cur_toc_next    = begin_entry;
          phase_next      = PhFirst;
        end
      end

      // closing word with status, then back to the header state
      if (payload.last_byte) begin
        unique case (phase_next)
          PhHeader: close_status = StShort;
          PhToc:    close_status = StTocOpen;
          PhDrain:  close_status = error_code_next;
          PhTrail:  close_status = StOk;
          default:  close_status = StTrunc;
        endcase
        res[n_res[0]].packet_done = 1'b1;
        res[n_res[0]].status      = close_status;
        res[n_res[0]].frames_done = frame_total_next;
        n_res                     = n_res + 1'b1;
        phase_next       = PhHeader;
        toc_count_next   = '0;
        toc_cursor_next  = '0;
        bytes_left_next  = '0;
        error_code_next  = StOk;
        frame_total_next = '0;
      end

      if (n_res != 2'd0) begin
        res[n_res[0] ^ 1'b1].run_end = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PhHeader;
      toc_count   <= '0;
      toc_cursor  <= '0;
      bytes_left  <= '0;
      error_code  <= StOk;
      frame_total <= '0;
    end else begin
      phase       <= phase_next;
      toc_count   <= toc_count_next;
      toc_cursor  <= toc_cursor_next;
      bytes_left  <= bytes_left_next;
      error_code  <= error_code_next;
      frame_total <= frame_total_next;
    end
    cur_toc  <= cur_toc_next;
    toc_head <= toc_head_next;
  end

  // output queue: up to two words pushed, one popped per cycle
  assign pop = result.valid & result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPtrW'(n_res);
      rd_ptr <= rd_ptr + QPtrW'(pop);
      fill   <= fill + QCntW'(n_res) - QCntW'(pop);
    end
    if (n_res != 2'd0) begin
      queue[wr_ptr] <= res[0];
    end
    if (n_res == 2'd2) begin
      queue[wr_ptr + 1'b1] <= res[1];
    end
  end

  assign result.valid       = (fill != '0);
  assign result.out_byte    = queue[rd_ptr].out_byte;
  assign result.byte_valid  = queue[rd_ptr].byte_valid;
  assign result.frame_start = queue[rd_ptr].frame_start;
  assign result.frame_end   = queue[rd_ptr].frame_end;
  assign result.packet_done = queue[rd_ptr].packet_done;
  assign result.status      = queue[rd_ptr].status;
  assign result.frames_done = queue[rd_ptr].frames_done;
  assign result.run_end     = queue[rd_ptr].run_end;

endmodule

@@ verif/amr_payload_toc_deframer_core_tb.sv @@
// self-checking testbench for amr_payload_toc_deframer_core: payloads in, frame stream checked
// depends on amr_toc_pkg, amr_toc_in_if / amr_toc_out_if and the core itself
`timescale 1ns / 100ps

module amr_payload_toc_deframer_core_tb;
  import amr_toc_pkg::*;

  // sizes of the random stimulus, counted in words the block acts on, the long receiver hold and the error print cap
  localparam int FirstGoal  = 550;
  localparam int SecondGoal = 1000;
  localparam int ThirdGoal  = 1250;
  localparam int LongHold   = 300;
  localparam int MaxPrinted = 100;

  // deframer progress through one payload
  typedef enum logic [2:0] {
    PhHeader,
    PhToc,
    PhFirst,
    PhBody,
    PhTrail,
    PhDrain
  } deframe_phase_t;

  // shapes of generated payload
  typedef enum int {
    PkGood,
    PkTrunc,
    PkBadType,
    PkFull,
    PkOpenToc,
    PkOverflow,
    PkShort,
    PkNoise
  } payload_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } payload_word_t;

  logic clk;
  logic rst;

  amr_toc_in_if  payload_bus ();
  amr_toc_out_if result_bus ();

  amr_payload_toc_deframer_core dut (
    .clk     (clk),
    .rst     (rst),
    .payload (payload_bus),
    .result  (result_bus)
  );

  // stimulus and expectation stores
  payload_word_t words_pending[$];
  result_t       due_words[$];

  // predictor state, one payload at a time
  deframe_phase_t dph;
  logic [7:0]     toc_mem [0:MaxToc-1];
  logic [4:0]     toc_n;
  logic [4:0]     toc_pos;
  logic [4:0]     bytes_to_go;
  logic [4:0]     frames_so_far;
  status_t        latched_err;

  // run bookkeeping
  int  errors;
  int  live_words;
  int  words_taken;
  int  results_checked;
  int  closes_checked;
  int  directed_payloads;
  int  packets_seen [0:7];
  bit  calm;
  bit  stall_req;
  int  snd_gap;
  int  rcv_gap;
  int  hold_left;
  payload_word_t next_word;
  result_t       want;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one line per mismatch; counting goes on after the print cap
  task automatic flag_error(input string what);
    if (errors < MaxPrinted) $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
    if (got !== exp_v)
      flag_error($sformatf("word %0d field %s: got %0h, expected %0h",
                           results_checked, name, got, exp_v));
  endtask

  // bytes of speech data per frame type index (0..8)
  function automatic logic [4:0] speech_bytes(input logic [3:0] ft);
    case (ft)
      4'd0:    return 5'd12;
      4'd1:    return 5'd13;
      4'd2:    return 5'd15;
      4'd3:    return 5'd17;
      4'd4:    return 5'd19;
      4'd5:    return 5'd20;
      4'd6:    return 5'd26;
      4'd7:    return 5'd31;
      default: return 5'd5;
    endcase
  endfunction

  function automatic result_t stream_word(input logic [7:0] b, input logic start,
                                          input logic stop);
    result_t r;
    r             = '0;
    r.out_byte    = b;
    r.byte_valid  = 1'b1;
    r.frame_start = start;
    r.frame_end   = stop;
    r.frames_done = frames_so_far;
    return r;
  endfunction

  // pick up the next table entry; types from NumTypes up stop the payload
  task automatic open_frame();
    logic [3:0] ti;
    ti = 4'hf;
    if (toc_pos < toc_n) ti = toc_mem[toc_pos][6:3];
    if (ti >= NumTypes) begin
      latched_err = StBadType;
      dph         = PhDrain;
    end else begin
      bytes_to_go = speech_bytes(ti);
      dph         = PhFirst;
    end
  endtask

  task automatic clear_deframe();
    dph           = PhHeader;
    toc_n         = '0;
    toc_pos       = '0;
    bytes_to_go   = '0;
    frames_so_far = '0;
    latched_err   = StOk;
  endtask

  // expected result words for one accepted payload word
  task automatic deframe_predict(input logic [7:0] b, input logic last);
    result_t made[$];
    result_t r;
    status_t st;
    case (dph)
      PhHeader: begin
        // cmr byte is dropped
        if (!last) dph = PhToc;
      end
      PhToc: begin
        if (toc_n < MaxToc) begin
          toc_mem[toc_n] = b;
          toc_n++;
        end
        // bit 7 set means another entry follows
        if (b[7]) begin
          if (toc_n >= MaxToc) begin
            latched_err = StTocOvf;
            dph         = PhDrain;
          end
        end else begin
          toc_pos = '0;
          open_frame();
        end
      end
      PhFirst, PhBody: begin
        // a payload ending inside a frame drops its final word
        if (!(last && bytes_to_go > 1)) begin
          if (dph == PhFirst) begin
            made.push_back(stream_word(toc_mem[toc_pos], 1'b1, 1'b0));
            dph = PhBody;
          end
          if (bytes_to_go > 0) bytes_to_go--;
          if (bytes_to_go == 0) begin
            if (frames_so_far != 5'd31) frames_so_far++;
            made.push_back(stream_word(b, 1'b0, 1'b1));
            toc_pos++;
            if (toc_pos >= toc_n) dph = PhTrail;
            else open_frame();
          end else begin
            made.push_back(stream_word(b, 1'b0, 1'b0));
          end
        end
      end
      default: ;
    endcase

    if (last) begin
      case (dph)
        PhHeader: st = StShort;
        PhToc:    st = StTocOpen;
        PhDrain:  st = latched_err;
        PhTrail:  st = StOk;
        default:  st = StTrunc;
      endcase
      r             = '0;
      r.packet_done = 1'b1;
      r.status      = st;
      r.frames_done = frames_so_far;
      made.push_back(r);
      clear_deframe();
    end

    if (made.size() > 0) made[made.size()-1].run_end = 1'b1;
    foreach (made[i]) due_words.push_back(made[i]);
  endtask

  // payload sender: holds a word until taken, random idle bursts between words
  always @(posedge clk) begin
    if (rst) begin
      payload_bus.valid <= 1'b0;
      snd_gap           <= 0;
      clear_deframe();
    end else begin
      if (payload_bus.valid && payload_bus.ready) begin
        words_taken++;
        deframe_predict(payload_bus.in_byte, payload_bus.last_byte);
      end
      if (!payload_bus.valid || payload_bus.ready) begin
        if (snd_gap > 0) begin
          snd_gap           <= snd_gap - 1;
          payload_bus.valid <= 1'b0;
        end else if (words_pending.size() == 0) begin
          payload_bus.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          snd_gap           <= $urandom_range(0, 14);
          payload_bus.valid <= 1'b0;
        end else begin
          next_word             = words_pending.pop_front();
          payload_bus.valid     <= 1'b1;
          payload_bus.in_byte   <= next_word.in_byte;
          payload_bus.last_byte <= next_word.last;
        end
      end
    end
  end

  // result receiver: checks each taken word, stalls in bursts or on a long hold request
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      rcv_gap          <= 0;
      hold_left        <= 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (due_words.size() == 0) begin
          flag_error("result word arrived with nothing due");
        end else begin
          want = due_words.pop_front();
          check_field("out_byte", result_bus.out_byte, want.out_byte);
          check_field("byte_valid", result_bus.byte_valid, want.byte_valid);
          check_field("frame_start", result_bus.frame_start, want.frame_start);
          check_field("frame_end", result_bus.frame_end, want.frame_end);
          check_field("packet_done", result_bus.packet_done, want.packet_done);
          check_field("status", result_bus.status, want.status);
          check_field("frames_done", result_bus.frames_done, want.frames_done);
          check_field("run_end", result_bus.run_end, want.run_end);
          if (want.packet_done) closes_checked++;
          results_checked++;
        end
      end
      if (stall_req) begin
        stall_req        <= 1'b0;
        hold_left        <= LongHold;
        result_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left        <= hold_left - 1;
        result_bus.ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap          <= rcv_gap - 1;
        result_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rcv_gap          <= $urandom_range(0, 14);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic last, input bit live);
    payload_word_t w;
    w.in_byte = b;
    w.last    = last;
    words_pending.push_back(w);
    if (live) live_words++;
  endtask

  // mostly well-formed payloads with random content, the rest broken or noise
  function automatic payload_kind_t pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return PkGood;
    if (roll < 62) return PkTrunc;
    if (roll < 72) return PkBadType;
    if (roll < 75) return PkFull;
    if (roll < 82) return PkOpenToc;
    if (roll < 87) return PkOverflow;
    if (roll < 92) return PkShort;
    return PkNoise;
  endfunction

  task automatic send_packet(input payload_kind_t kind);
    logic [7:0] seq[$];
    bit         act[$];
    logic [3:0] ft[$];
    logic [3:0] t;
    logic       more;
    int         n;
    int         bad_at;
    int         cut_frame;
    int         len;
    // cmr header word, dropped by the block
    seq.push_back(8'($urandom));
    act.push_back(1'b1);
    case (kind)
      PkShort: ;
      PkNoise: begin
        repeat ($urandom_range(0, 39)) begin
          seq.push_back(8'($urandom));
          act.push_back(1'b1);
        end
      end
      PkOpenToc: begin
        // list never terminated, still short of the store size
        repeat ($urandom_range(1, MaxToc - 1)) begin
          seq.push_back({1'b1, 7'($urandom)});
          act.push_back(1'b1);
        end
      end
      PkOverflow: begin
        repeat (MaxToc) begin
          seq.push_back({1'b1, 7'($urandom)});
          act.push_back(1'b1);
        end
        repeat ($urandom_range(0, 4)) begin
          seq.push_back(8'($urandom));
          act.push_back(1'b0);
        end
      end
      default: begin
        n         = (kind == PkFull) ? MaxToc : $urandom_range(1, 4);
        bad_at    = (kind == PkBadType) ? $urandom_range(0, n - 1) : n;
        cut_frame = (kind == PkTrunc) ? $urandom_range(0, n - 1) : n;
        for (int i = 0; i < n; i++) begin
          if (i == bad_at) t = 4'($urandom_range(9, 15));
          else if (kind == PkFull && $urandom_range(0, 3) != 0) t = 4'd8;
          else t = 4'($urandom_range(0, 8));
          more = (i < n - 1);
          ft.push_back(t);
          seq.push_back({more, t, 3'($urandom)});
          act.push_back(1'b1);
        end
        for (int i = 0; i < n && i < bad_at; i++) begin
          len = speech_bytes(ft[i]);
          // truncation stops somewhere before the frame's final word
          if (i == cut_frame) len = $urandom_range(1, len - 1);
          repeat (len) begin
            seq.push_back(8'($urandom));
            act.push_back(1'b1);
          end
          if (i == cut_frame) break;
        end
        // trailing words after the frames, or drained words after a bad type
        if (kind != PkTrunc) begin
          repeat ($urandom_range(0, 3)) begin
            seq.push_back(8'($urandom));
            act.push_back(1'b0);
          end
        end
      end
    endcase
    foreach (seq[i])
      push_word(seq[i], i == seq.size() - 1, act[i] || i == seq.size() - 1);
    packets_seen[kind]++;
  endtask

  // sender pause: nothing new until every due result word has come back
  task automatic wait_quiet();
    while (words_pending.size() != 0 || payload_bus.valid || due_words.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int guard;
    payload_bus.valid     = 1'b0;
    payload_bus.in_byte   = '0;
    payload_bus.last_byte = 1'b0;
    result_bus.ready      = 1'b0;
    rst                   = 1'b1;
    calm                  = 1'b0;
    stall_req             = 1'b0;
    errors                = 0;
    live_words            = 0;
    words_taken           = 0;
    results_checked       = 0;
    closes_checked        = 0;
    foreach (packets_seen[i]) packets_seen[i] = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: short payload, header word marked last
    push_word(8'hff, 1'b1, 1'b1);
    // one type 8 frame, five words, extremes of the data byte
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h40, 1'b0, 1'b1);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hff, 1'b0, 1'b1);
    push_word(8'h55, 1'b0, 1'b1);
    push_word(8'haa, 1'b0, 1'b1);
    push_word(8'h01, 1'b1, 1'b1);
    // toc list still open at the last word
    push_word(8'ha5, 1'b0, 1'b1);
    push_word(8'hff, 1'b1, 1'b1);
    // bad type 15, then bad type 9
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h7f, 1'b0, 1'b1);
    push_word(8'h80, 1'b1, 1'b1);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h4b, 1'b0, 1'b1);
    push_word(8'h00, 1'b1, 1'b1);
    // frame truncated mid body
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h44, 1'b0, 1'b1);
    push_word(8'h12, 1'b0, 1'b1);
    push_word(8'h34, 1'b0, 1'b1);
    push_word(8'h56, 1'b1, 1'b1);
    // payload ends on the very first data word: only the closing word emitted
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h12, 1'b1, 1'b1);
    directed_payloads = 7;
    wait_quiet();

    // first random stretch, with one long receiver hold so the input backs up
    while (live_words < FirstGoal) send_packet(pick_kind());
    stall_req = 1'b1;
    wait_quiet();

    while (live_words < SecondGoal) send_packet(pick_kind());
    wait_quiet();

    // last stretch at full rate on both sides
    calm = 1'b1;
    while (live_words < ThirdGoal) send_packet(pick_kind());

    while (words_pending.size() != 0 || payload_bus.valid) @(negedge clk);
    guard = 0;
    while (due_words.size() != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (due_words.size() != 0)
      flag_error($sformatf("%0d result words never arrived", due_words.size()));

    $display("payloads: %0d directed, %0d complete, %0d truncated, %0d bad type, %0d full toc,",
             directed_payloads, packets_seen[PkGood], packets_seen[PkTrunc],
             packets_seen[PkBadType], packets_seen[PkFull]);
    $display("  %0d open toc, %0d overflow, %0d short, %0d noise; %0d words in, %0d out (%0d closes)",
             packets_seen[PkOpenToc], packets_seen[PkOverflow], packets_seen[PkShort],
             packets_seen[PkNoise], words_taken, results_checked, closes_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // overall watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("watchdog expired with %0d result words still due", due_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ amr_payload_toc_deframer_core.f @@
sv/amr_toc_pkg.sv
sv/amr_toc_if.sv
sv/amr_payload_toc_deframer_core.sv
verif/amr_payload_toc_deframer_core_tb.sv
